[rtl/jls_pkg.sv]
// Package for the jittered light splitter: constants and the control/status
// structs shared by controller and datapath. No dependencies.
`default_nettype none
package jls_pkg;
  localparam int unsigned DefMaxCopies = 64;
  localparam int unsigned DefMaxTries  = 16;

  localparam logic [31:0] FnvBasis = 32'd2166136261;
  localparam logic [31:0] FnvPrime = 32'd16777619;
  localparam logic [31:0] LcgMul   = 32'd1664525;
  localparam logic [31:0] LcgAdd   = 32'd1013904223;
  localparam logic [23:0] FracMask = 24'hFFFFFF;
  localparam logic [25:0] FracOne  = 26'h1000000;
  localparam logic [49:0] RadLimit = 50'h1000000000000;

  localparam logic [1:0] SelX    = 2'd0;
  localparam logic [1:0] SelY    = 2'd1;
  localparam logic [1:0] SelZ    = 2'd2;
  localparam logic [1:0] SelSalt = 2'd3;

  typedef struct packed {
    logic       load_in;
    logic       pass_load;
    logic       hash_en;
    logic [1:0] hash_sel;
    logic       div_en;
    logic       seed_load;
    logic       gen_step;
    logic       acc_clr;
    logic       sq_en;
    logic [1:0] sq_idx;
    logic       test;
    logic       scale_en;
    logic       pos_en;
    logic       last;
  } jls_cmd_t;

  typedef struct packed {
    logic       no_split;
    logic       acc_ok;
    logic [6:0] count;
  } jls_stat_t;
endpackage
`default_nettype wire

[rtl/jls_dp.sv]
// Datapath of the jittered light splitter: hash, LCG, sphere test, color
// divider, scaling and saturation. Depends on jls_pkg.
`default_nettype none
module jls_dp import jls_pkg::*; #(
  parameter int unsigned MAX_COPIES = DefMaxCopies
) (
  input  wire logic               clk,
  input  wire logic signed [31:0] in_pos_x,
  input  wire logic signed [31:0] in_pos_y,
  input  wire logic signed [31:0] in_pos_z,
  input  wire logic        [15:0] in_color_red,
  input  wire logic        [15:0] in_color_green,
  input  wire logic        [15:0] in_color_blue,
  input  wire logic        [19:0] in_spread,
  input  wire logic        [6:0]  in_copy_count,
  input  wire logic        [31:0] in_salt,
  input  wire jls_cmd_t           cmd,
  output jls_stat_t               stat,
  output logic signed [31:0]      out_x,
  output logic signed [31:0]      out_y,
  output logic signed [31:0]      out_z,
  output logic        [15:0]      out_red,
  output logic        [15:0]      out_green,
  output logic        [15:0]      out_blue,
  output logic                    last_copy
);
  localparam logic [6:0] MaxCnt = 7'(MAX_COPIES);

  logic signed [31:0] base_r [3];
  logic [31:0] salt_r, h_r, lcg_r;
  logic [19:0] spread_r;
  logic [6:0]  cnt_r;
  logic [15:0] q_r [3];
  logic [7:0]  rem_r [3];
  logic signed [25:0] c_r [3];
  logic [49:0] acc_r;
  logic        hit_r;
  logic signed [46:0] p_r [3];

  logic [6:0]  cnt_in;
  logic [31:0] hw;
  logic signed [25:0] coord;
  logic [51:0] sq;

  assign cnt_in = (in_copy_count > MaxCnt) ? MaxCnt : in_copy_count;
  assign stat.no_split = (in_spread == 20'd0) || (in_copy_count <= 7'd1);
  assign stat.acc_ok = (acc_r <= RadLimit);
  assign stat.count = cnt_r;

  always_comb begin
    unique case (cmd.hash_sel)
      SelX:    hw = base_r[0];
      SelY:    hw = base_r[1];
      SelZ:    hw = base_r[2];
      default: hw = salt_r;
    endcase
  end

  assign coord = $signed({1'b0, lcg_r[23:0] & FracMask, 1'b0}) - $signed(FracOne);
  assign sq = 52'($signed(coord) * $signed(coord));

  always_ff @(posedge clk) begin
    logic [7:0] rs;
    logic [46:0] mag;
    logic signed [22:0] off;
    logic signed [32:0] sum;
    if (cmd.load_in) begin
      base_r[0] <= in_pos_x;
      base_r[1] <= in_pos_y;
      base_r[2] <= in_pos_z;
      salt_r    <= in_salt;
      spread_r  <= in_spread;
      cnt_r     <= cnt_in;
      h_r       <= FnvBasis;
      q_r[0]    <= in_color_red;
      q_r[1]    <= in_color_green;
      q_r[2]    <= in_color_blue;
      for (int i = 0; i < 3; i++) rem_r[i] <= 8'd0;
    end
    if (cmd.hash_en) h_r <= (h_r ^ hw) * FnvPrime;
    if (cmd.div_en) begin
      for (int i = 0; i < 3; i++) begin
        rs = {rem_r[i][6:0], q_r[i][15]};
        if (rs >= {1'b0, cnt_r}) begin
          rem_r[i] <= rs - {1'b0, cnt_r};
          q_r[i]   <= {q_r[i][14:0], 1'b1};
        end else begin
          rem_r[i] <= rs;
          q_r[i]   <= {q_r[i][14:0], 1'b0};
        end
      end
    end
    if (cmd.seed_load) lcg_r <= (h_r == 32'd0) ? 32'd1 : h_r;
    else if (cmd.gen_step) lcg_r <= lcg_r * LcgMul + LcgAdd;
    if (cmd.acc_clr) acc_r <= 50'd0;
    else if (cmd.sq_en) begin
      acc_r <= acc_r + sq[49:0];
      c_r[cmd.sq_idx] <= coord;
    end
    if (cmd.test) hit_r <= stat.acc_ok;
    if (cmd.scale_en) begin
      for (int i = 0; i < 3; i++)
        p_r[i] <= 47'($signed(c_r[i]) * $signed({1'b0, spread_r}));
    end
    if (cmd.pass_load) begin
      out_x <= in_pos_x;
      out_y <= in_pos_y;
      out_z <= in_pos_z;
      out_red <= in_color_red;
      out_green <= in_color_green;
      out_blue <= in_color_blue;
      last_copy <= 1'b1;
    end else if (cmd.pos_en) begin
      for (int i = 0; i < 3; i++) begin
        mag = p_r[i][46] ? 47'(-p_r[i]) : 47'(p_r[i]);
        off = $signed({1'b0, 22'((mag + 47'h800000) >> 24)});
        if (p_r[i][46]) off = -off;
        if (!hit_r) off = '0;
        sum = 33'(base_r[i]) + 33'(off);
        if (sum > 33'sh07FFFFFFF) sum = 33'sh07FFFFFFF;
        else if (sum < -33'sh080000000) sum = -33'sh080000000;
        unique case (i)
          0:       out_x <= sum[31:0];
          1:       out_y <= sum[31:0];
          default: out_z <= sum[31:0];
        endcase
      end
      out_red   <= q_r[0];
      out_green <= q_r[1];
      out_blue  <= q_r[2];
      last_copy <= cmd.last;
    end
  end
endmodule
`default_nettype wire

[rtl/jls_ctrl.sv]
// Controller of the jittered light splitter: sequences hash, divide,
// rejection tries and copy output. Depends on jls_pkg.
`default_nettype none
module jls_ctrl import jls_pkg::*; #(
  parameter int unsigned MAX_TRIES = DefMaxTries
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  wire logic out_stall,
  input  wire jls_stat_t stat,
  output jls_cmd_t  cmd
);
  localparam int unsigned TW = $clog2(MAX_TRIES + 1);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_PREP  = 7'b0000010,
    ST_GEN   = 7'b0000100,
    ST_TEST  = 7'b0001000,
    ST_SCALE = 7'b0010000,
    ST_POS   = 7'b0100000,
    ST_OUT   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic [3:0] pcnt_r, pcnt_nxt;
  logic [1:0] axis_r, axis_nxt;
  logic [TW-1:0] tries_r, tries_nxt;
  logic [6:0] copy_r, copy_nxt;
  logic last_r, last_nxt, ov_r, ov_nxt;

  assign in_stall = (state_r != ST_IDLE);
  assign out_valid = ov_r;

  always_comb begin
    state_nxt = state_r;
    pcnt_nxt = pcnt_r;
    axis_nxt = axis_r;
    tries_nxt = tries_r;
    copy_nxt = copy_r;
    last_nxt = last_r;
    ov_nxt = ov_r;
    cmd = '0;
    cmd.hash_sel = pcnt_r[1:0];
    cmd.sq_idx = axis_r - 2'd1;
    cmd.last = (copy_r + 7'd1 == stat.count);
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          if (stat.no_split) begin
            cmd.pass_load = 1'b1;
            ov_nxt = 1'b1;
            last_nxt = 1'b1;
            state_nxt = ST_OUT;
          end else begin
            pcnt_nxt = 4'd0;
            state_nxt = ST_PREP;
          end
        end
      end
      ST_PREP: begin
        cmd.hash_en = (pcnt_r < 4'd4);
        cmd.div_en = 1'b1;
        pcnt_nxt = pcnt_r + 4'd1;
        if (pcnt_r == 4'd15) begin
          cmd.seed_load = 1'b1;
          axis_nxt = 2'd0;
          tries_nxt = '0;
          copy_nxt = 7'd0;
          state_nxt = ST_GEN;
        end
      end
      ST_GEN: begin
        cmd.acc_clr = (axis_r == 2'd0);
        cmd.gen_step = (axis_r != 2'd3);
        cmd.sq_en = (axis_r != 2'd0);
        axis_nxt = axis_r + 2'd1;
        if (axis_r == 2'd3) state_nxt = ST_TEST;
      end
      ST_TEST: begin
        cmd.test = 1'b1;
        tries_nxt = tries_r + 1'b1;
        axis_nxt = 2'd0;
        if (stat.acc_ok || (tries_r + 1'b1 == TW'(MAX_TRIES))) state_nxt = ST_SCALE;
        else state_nxt = ST_GEN;
      end
      ST_SCALE: begin
        cmd.scale_en = 1'b1;
        state_nxt = ST_POS;
      end
      ST_POS: begin
        cmd.pos_en = 1'b1;
        last_nxt = cmd.last;
        copy_nxt = copy_r + 7'd1;
        ov_nxt = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_stall) begin
          ov_nxt = 1'b0;
          tries_nxt = '0;
          axis_nxt = 2'd0;
          state_nxt = last_r ? ST_IDLE : ST_GEN;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pcnt_r <= '0;
      axis_r <= '0;
      tries_r <= '0;
      copy_r <= '0;
      last_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pcnt_r <= pcnt_nxt;
      axis_r <= axis_nxt;
      tries_r <= tries_nxt;
      copy_r <= copy_nxt;
      last_r <= last_nxt;
      ov_r <= ov_nxt;
    end
  end
endmodule
`default_nettype wire

[rtl/jittered_light_splitter.sv]
// Top level of the jittered light splitter: controller plus datapath.
// Depends on jls_pkg, jls_ctrl and jls_dp.
//
// Usage: present one light on the in_ ports with in_valid; it is taken at a
// clock edge where in_valid is high and in_stall is low. One light is
// worked at a time; in_stall stays high until its last copy is taken.
// A light with zero spread or a count of at most one comes out once,
// unchanged, in the cycle after acceptance, with last_copy set.
// Otherwise the generator is seeded (FNV hash) while the bit-serial color
// divider runs; then each copy makes rejection tries (three generator steps,
// squares accumulated, radius test), then is scaled, added and saturated,
// and one item waits in the output register until taken. Typical lights
// need about 1.9 tries; each copy makes at most MAX_TRIES tries.
// out_stall holds the waiting item and freezes the sequencer.
// Reset (rst_n low, synchronous) drops any light in progress and clears
// out_valid.
`default_nettype none
module jittered_light_splitter import jls_pkg::*; #(
  parameter int unsigned MAX_COPIES = DefMaxCopies,
  parameter int unsigned MAX_TRIES  = DefMaxTries
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [31:0] in_pos_x,
  input  wire logic signed [31:0] in_pos_y,
  input  wire logic signed [31:0] in_pos_z,
  input  wire logic        [15:0] in_color_red,
  input  wire logic        [15:0] in_color_green,
  input  wire logic        [15:0] in_color_blue,
  input  wire logic        [19:0] in_spread,
  input  wire logic        [6:0]  in_copy_count,
  input  wire logic        [31:0] in_salt,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      out_x,
  output logic signed [31:0]      out_y,
  output logic signed [31:0]      out_z,
  output logic        [15:0]      out_red,
  output logic        [15:0]      out_green,
  output logic        [15:0]      out_blue,
  output logic                    out_last_copy
);
  jls_cmd_t  cmd;
  jls_stat_t stat;

  // Sequencer: owns the handshakes and all loop counters.
  jls_ctrl #(.MAX_TRIES(MAX_TRIES)) u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall,
    .stat, .cmd
  );

  // Arithmetic and the output register.
  jls_dp #(.MAX_COPIES(MAX_COPIES)) u_dp (
    .clk, .in_pos_x, .in_pos_y, .in_pos_z,
    .in_color_red, .in_color_green, .in_color_blue,
    .in_spread, .in_copy_count, .in_salt,
    .cmd, .stat, .out_x, .out_y, .out_z,
    .out_red, .out_green, .out_blue, .last_copy(out_last_copy)
  );
endmodule
`default_nettype wire
